// ----- rtl/ddo_pkg.sv -----
// shared constants, types and tables for the differential drive odometry block
package ddo_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 24;

   localparam int DATA_W      = 32;
   localparam int DPC_W       = 24;
   localparam int RATE_W      = 16;
   localparam int SPACING_W   = 31;
   localparam int CSR_DATA_W  = 31;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DISTANCE_PER_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_RATE_HZ     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHEEL_SPACING      = 2'd2;

   localparam logic [DPC_W-1:0]     DPC_RESET     = 24'd69578;
   localparam logic [RATE_W-1:0]    RATE_RESET    = 16'd250;
   localparam logic [SPACING_W-1:0] SPACING_RESET = 31'd18428723;

   localparam int DIFF_W     = DATA_W + 1;
   localparam int TRAVEL_W   = DIFF_W + DPC_W - (32 - FRAC_BITS);
   localparam int SUM_W      = TRAVEL_W + 1;
   localparam int PROD_W     = 72;
   localparam int MPL_W      = 33;
   localparam int DIV_NUM_W  = SUM_W + 37;
   localparam int DIV_STEPS  = 32;
   localparam int HEAD_W     = 36;
   localparam int CORD_W     = 34;
   localparam int CNT_W      = 6;
   localparam int STEP_IDX_W = 5;

   localparam logic signed [HEAD_W-1:0] PI_Q29      = 36'sd1686629713;
   localparam logic signed [HEAD_W-1:0] TWO_PI_Q29  = 36'sd3373259426;
   localparam logic signed [HEAD_W-1:0] HALF_PI_Q29 = 36'sd843314857;
   localparam logic signed [CORD_W-1:0] GAIN_Q30    = 34'sd652032874;

   typedef logic signed [PROD_W-1:0] prod_type;

   function automatic logic signed [DATA_W-1:0] sat32(input prod_type v);
      prod_type hi;
      prod_type lo;
      hi = prod_type'(64'sd2147483647);
      lo = prod_type'(-64'sd2147483648);
      if (v > hi) begin
         sat32 = 32'sh7fff_ffff;
      end else if (v < lo) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[DATA_W-1:0];
      end
   endfunction

   // arctangent of 2^-i in q29, rounded
   function automatic logic [31:0] atan_q29(input logic [STEP_IDX_W-1:0] idx);
      case (idx)
         5'd0:  atan_q29 = 32'd421657428;
         5'd1:  atan_q29 = 32'd248918915;
         5'd2:  atan_q29 = 32'd131521918;
         5'd3:  atan_q29 = 32'd66762579;
         5'd4:  atan_q29 = 32'd33510843;
         5'd5:  atan_q29 = 32'd16771758;
         5'd6:  atan_q29 = 32'd8387925;
         5'd7:  atan_q29 = 32'd4194219;
         5'd8:  atan_q29 = 32'd2097141;
         5'd9:  atan_q29 = 32'd1048575;
         5'd10: atan_q29 = 32'd524288;
         5'd11: atan_q29 = 32'd262144;
         5'd12: atan_q29 = 32'd131072;
         5'd13: atan_q29 = 32'd65536;
         5'd14: atan_q29 = 32'd32768;
         5'd15: atan_q29 = 32'd16384;
         5'd16: atan_q29 = 32'd8192;
         5'd17: atan_q29 = 32'd4096;
         5'd18: atan_q29 = 32'd2048;
         5'd19: atan_q29 = 32'd1024;
         5'd20: atan_q29 = 32'd512;
         5'd21: atan_q29 = 32'd256;
         5'd22: atan_q29 = 32'd128;
         5'd23: atan_q29 = 32'd64;
         5'd24: atan_q29 = 32'd32;
         5'd25: atan_q29 = 32'd16;
         5'd26: atan_q29 = 32'd8;
         5'd27: atan_q29 = 32'd4;
         5'd28: atan_q29 = 32'd2;
         5'd29: atan_q29 = 32'd1;
         default: atan_q29 = 32'd0;
      endcase
   endfunction

endpackage

// ----- rtl/differential_drive_odometry.sv -----
// differential drive wheel odometry: encoder counts in, pose and speeds out
//
// an item on the req channel carries the right and left encoder counts; it is
// taken when req_valid is high and req_stall is low. one result item per input
// item leaves on the rsp channel with x, y, heading and four speeds.
// all arithmetic runs on one bit-serial multiplier, one restoring divider and
// one cordic stage under a small sequencer. an item takes eight multiplies,
// two divides and 24 cordic iterations. req_stall is high for the whole item.
// the result sits in an output register, so a new item is taken while the
// previous result still waits; a stalled receiver holds the result and the
// next item waits at its last step until the output register frees up.
// csr writes take effect at once and are meant for idle periods.
// reset (synchronous, active high) clears pose, heading, the previous counts
// and loads the default configuration.
module differential_drive_odometry (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic signed [ddo_pkg::DATA_W-1:0]          req_right_count,
   input  logic signed [ddo_pkg::DATA_W-1:0]          req_left_count,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [ddo_pkg::DATA_W-1:0]          rsp_x_position,
   output logic signed [ddo_pkg::DATA_W-1:0]          rsp_y_position,
   output logic signed [ddo_pkg::DATA_W-1:0]          rsp_heading,
   output logic signed [ddo_pkg::DATA_W-1:0]          rsp_right_speed,
   output logic signed [ddo_pkg::DATA_W-1:0]          rsp_left_speed,
   output logic signed [ddo_pkg::DATA_W-1:0]          rsp_linear_speed,
   output logic signed [ddo_pkg::DATA_W-1:0]          rsp_angular_speed,
   input  logic                                       csr_write,
   input  logic [ddo_pkg::CSR_INDEX_W-1:0]            csr_index,
   input  logic [ddo_pkg::CSR_DATA_W-1:0]             csr_wdata
);

   localparam int DATA_W    = ddo_pkg::DATA_W;
   localparam int DIFF_W    = ddo_pkg::DIFF_W;
   localparam int TRAVEL_W  = ddo_pkg::TRAVEL_W;
   localparam int SUM_W     = ddo_pkg::SUM_W;
   localparam int PROD_W    = ddo_pkg::PROD_W;
   localparam int MPL_W     = ddo_pkg::MPL_W;
   localparam int DIV_NUM_W = ddo_pkg::DIV_NUM_W;
   localparam int HEAD_W    = ddo_pkg::HEAD_W;
   localparam int CORD_W    = ddo_pkg::CORD_W;
   localparam int CNT_W     = ddo_pkg::CNT_W;
   localparam int SPACING_W = ddo_pkg::SPACING_W;
   localparam int HI_W      = DIV_NUM_W - 32;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_NEXT = 3'd3;
   localparam logic [2:0] ST_WRAP = 3'd4;
   localparam logic [2:0] ST_FOLD = 3'd5;
   localparam logic [2:0] ST_CORD = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   localparam logic [3:0] STEP_TR      = 4'd0;
   localparam logic [3:0] STEP_TL      = 4'd1;
   localparam logic [3:0] STEP_VR      = 4'd2;
   localparam logic [3:0] STEP_VL      = 4'd3;
   localparam logic [3:0] STEP_LIN     = 4'd4;
   localparam logic [3:0] STEP_ANG_MUL = 4'd5;
   localparam logic [3:0] STEP_ANG_DIV = 4'd6;
   localparam logic [3:0] STEP_DTH     = 4'd7;
   localparam logic [3:0] STEP_COS     = 4'd8;
   localparam logic [3:0] STEP_PX      = 4'd9;
   localparam logic [3:0] STEP_PY      = 4'd10;

   localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MPL_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(ddo_pkg::DIV_STEPS);
   localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(ddo_pkg::CORDIC_STEPS - 1);

   localparam logic signed [SUM_W-1:0] MT_MAX = SUM_W'(64'sd4294967296);
   localparam logic signed [SUM_W-1:0] MT_MIN = SUM_W'(-64'sd4294967296);

   logic [2:0]                          state_ff, state_in;
   logic [3:0]                          step_ff, step_in;
   logic [CNT_W-1:0]                    cnt_ff, cnt_in;
   logic [ddo_pkg::DPC_W-1:0]           dpc_ff, dpc_in;
   logic [ddo_pkg::RATE_W-1:0]          rate_ff, rate_in;
   logic [SPACING_W-1:0]                spacing_ff, spacing_in;
   logic signed [DATA_W-1:0]            prev_right_ff, prev_right_in;
   logic signed [DATA_W-1:0]            prev_left_ff, prev_left_in;
   logic signed [DATA_W-1:0]            pos_x_ff, pos_x_in;
   logic signed [DATA_W-1:0]            pos_y_ff, pos_y_in;
   logic signed [DATA_W-1:0]            angle_ff, angle_in;
   logic signed [DIFF_W-1:0]            dl_ff, dl_in;
   logic signed [TRAVEL_W-1:0]          tr_ff, tr_in;
   logic signed [TRAVEL_W-1:0]          tl_ff, tl_in;
   logic signed [DATA_W-1:0]            vr_ff, vr_in;
   logic signed [DATA_W-1:0]            vl_ff, vl_in;
   logic signed [DATA_W-1:0]            lin_ff, lin_in;
   logic signed [DATA_W-1:0]            ang_ff, ang_in;
   logic signed [HEAD_W-1:0]            nw_ff, nw_in;
   logic signed [HEAD_W-1:0]            z_ff, z_in;
   logic signed [CORD_W-1:0]            cx_ff, cx_in;
   logic signed [CORD_W-1:0]            cy_ff, cy_in;
   logic                                flip_ff, flip_in;
   ddo_pkg::prod_type                   acc_ff, acc_in;
   ddo_pkg::prod_type                   mcand_ff, mcand_in;
   logic [MPL_W-1:0]                    mplier_ff, mplier_in;
   logic                                neg_ff, neg_in;
   logic [DIV_NUM_W-1:0]                num_ff, num_in;
   logic [SPACING_W-1:0]                rem_ff, rem_in;
   logic [31:0]                         quo_ff, quo_in;
   logic                                ovf_ff, ovf_in;
   logic                                dneg_ff, dneg_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]            out_x_ff, out_x_in;
   logic signed [DATA_W-1:0]            out_y_ff, out_y_in;
   logic signed [DATA_W-1:0]            out_head_ff, out_head_in;
   logic signed [DATA_W-1:0]            out_vr_ff, out_vr_in;
   logic signed [DATA_W-1:0]            out_vl_ff, out_vl_in;
   logic signed [DATA_W-1:0]            out_lin_ff, out_lin_in;
   logic signed [DATA_W-1:0]            out_ang_ff, out_ang_in;

   logic [SPACING_W-1:0]                sp;

   assign sp = (spacing_ff == '0) ? SPACING_W'(1) : spacing_ff;

   always_comb begin
      ddo_pkg::prod_type         prod;
      ddo_pkg::prod_type         pstep;
      logic signed [SUM_W-1:0]   sum;
      logic signed [SUM_W-1:0]   diff;
      logic [SUM_W-1:0]          un;
      logic signed [SUM_W-1:0]   half;
      logic signed [SUM_W-1:0]   mt;
      logic [MPL_W-1:0]          mt_mag;
      logic [31:0]               qcap;
      logic signed [32:0]        qsig;
      logic [HI_W-1:0]           hi;
      logic [31:0]               dtrial;
      logic [31:0]               dsub;
      logic                      ge;
      logic signed [CORD_W-1:0]  xs;
      logic signed [CORD_W-1:0]  ys;
      logic signed [HEAD_W-1:0]  at;
      logic signed [HEAD_W-1:0]  nw_new;
      logic signed [HEAD_W:0]    mid_sum;
      logic signed [HEAD_W-1:0]  hw;
      logic signed [DATA_W-1:0]  rdiff;
      logic signed [DATA_W-1:0]  ldiff;
      logic                      mul_go;
      ddo_pkg::prod_type         mul_a;
      logic [MPL_W-1:0]          mul_b;
      logic                      mul_n;
      logic                      div_go;
      logic [DIV_NUM_W-1:0]      div_n;

      state_in      = state_ff;
      step_in       = step_ff;
      cnt_in        = cnt_ff;
      dpc_in        = dpc_ff;
      rate_in       = rate_ff;
      spacing_in    = spacing_ff;
      prev_right_in = prev_right_ff;
      prev_left_in  = prev_left_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      angle_in      = angle_ff;
      dl_in         = dl_ff;
      tr_in         = tr_ff;
      tl_in         = tl_ff;
      vr_in         = vr_ff;
      vl_in         = vl_ff;
      lin_in        = lin_ff;
      ang_in        = ang_ff;
      nw_in         = nw_ff;
      z_in          = z_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      flip_in       = flip_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      neg_in        = neg_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      ovf_in        = ovf_ff;
      dneg_in       = dneg_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_head_in   = out_head_ff;
      out_vr_in     = out_vr_ff;
      out_vl_in     = out_vl_ff;
      out_lin_in    = out_lin_ff;
      out_ang_in    = out_ang_ff;

      mul_go = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      mul_n  = 1'b0;
      div_go = 1'b0;
      div_n  = '0;

      prod  = neg_ff ? -acc_ff : acc_ff;
      pstep = prod >>> 30;
      sum   = SUM_W'(tr_ff) + SUM_W'(tl_ff);
      diff  = SUM_W'(tr_ff) - SUM_W'(tl_ff);
      un    = diff[SUM_W-1] ? SUM_W'(-diff) : SUM_W'(diff);
      half  = sum >>> 1;
      if (half > MT_MAX) begin
         mt = MT_MAX;
      end else if (half < MT_MIN) begin
         mt = MT_MIN;
      end else begin
         mt = half;
      end
      mt_mag = mt[SUM_W-1] ? MPL_W'(-mt) : MPL_W'(mt);

      qcap = (ovf_ff || quo_ff > 32'h8000_0000) ? 32'h8000_0000 : quo_ff;
      qsig = dneg_ff ? -$signed({1'b0, qcap}) : $signed({1'b0, qcap});

      hi     = num_ff[DIV_NUM_W-1:32];
      dtrial = {rem_ff, num_ff[31]};
      dsub   = dtrial - {1'b0, sp};
      ge     = dtrial >= {1'b0, sp};

      xs = cx_ff >>> cnt_ff;
      ys = cy_ff >>> cnt_ff;
      at = HEAD_W'(ddo_pkg::atan_q29(cnt_ff[ddo_pkg::STEP_IDX_W-1:0]));

      nw_new  = HEAD_W'(angle_ff) + HEAD_W'(qsig);
      mid_sum = (HEAD_W+1)'(angle_ff) + (HEAD_W+1)'(nw_new);

      hw = nw_ff;
      if (hw > ddo_pkg::PI_Q29) begin
         hw = hw - ddo_pkg::TWO_PI_Q29;
      end
      if (hw < -ddo_pkg::PI_Q29) begin
         hw = hw + ddo_pkg::TWO_PI_Q29;
      end

      rdiff = req_right_count - prev_right_ff;
      ldiff = req_left_count - prev_left_ff;

      if (csr_write) begin
         unique case (csr_index)
            ddo_pkg::CSR_DISTANCE_PER_COUNT: dpc_in = csr_wdata[ddo_pkg::DPC_W-1:0];
            ddo_pkg::CSR_SAMPLE_RATE_HZ:     rate_in = csr_wdata[ddo_pkg::RATE_W-1:0];
            ddo_pkg::CSR_WHEEL_SPACING:      spacing_in = csr_wdata[SPACING_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               prev_right_in = req_right_count;
               prev_left_in  = req_left_count;
               dl_in         = -DIFF_W'(ldiff);
               step_in       = STEP_TR;
               mul_go        = 1'b1;
               mul_a         = PROD_W'(rdiff);
               mul_b         = MPL_W'(dpc_ff);
            end
         end
         ST_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_NEXT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               ovf_in = hi >= HI_W'(sp);
               rem_in = hi[SPACING_W-1:0];
               quo_in = '0;
            end else begin
               rem_in = ge ? dsub[SPACING_W-1:0] : dtrial[SPACING_W-1:0];
               quo_in = {quo_ff[30:0], ge};
               num_in = num_ff << 1;
            end
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_NEXT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_NEXT: begin
            unique case (step_ff)
               STEP_TR: begin
                  tr_in   = TRAVEL_W'(prod >>> (32 - ddo_pkg::FRAC_BITS));
                  step_in = STEP_TL;
                  mul_go  = 1'b1;
                  mul_a   = PROD_W'(dl_ff);
                  mul_b   = MPL_W'(dpc_ff);
               end
               STEP_TL: begin
                  tl_in   = TRAVEL_W'(prod >>> (32 - ddo_pkg::FRAC_BITS));
                  step_in = STEP_VR;
                  mul_go  = 1'b1;
                  mul_a   = PROD_W'(tr_ff);
                  mul_b   = MPL_W'(rate_ff);
               end
               STEP_VR: begin
                  vr_in   = ddo_pkg::sat32(prod);
                  step_in = STEP_VL;
                  mul_go  = 1'b1;
                  mul_a   = PROD_W'(tl_ff);
                  mul_b   = MPL_W'(rate_ff);
               end
               STEP_VL: begin
                  vl_in   = ddo_pkg::sat32(prod);
                  step_in = STEP_LIN;
                  mul_go  = 1'b1;
                  mul_a   = PROD_W'(sum);
                  mul_b   = MPL_W'(rate_ff);
               end
               STEP_LIN: begin
                  lin_in  = ddo_pkg::sat32(prod >>> 1);
                  dneg_in = diff[SUM_W-1];
                  step_in = STEP_ANG_MUL;
                  mul_go  = 1'b1;
                  mul_a   = PROD_W'(un);
                  mul_b   = MPL_W'(rate_ff);
               end
               STEP_ANG_MUL: begin
                  step_in = STEP_ANG_DIV;
                  div_go  = 1'b1;
                  div_n   = DIV_NUM_W'(prod) << 16;
               end
               STEP_ANG_DIV: begin
                  ang_in  = ddo_pkg::sat32(PROD_W'(qsig));
                  step_in = STEP_DTH;
                  div_go  = 1'b1;
                  div_n   = DIV_NUM_W'(un) << (45 - ddo_pkg::FRAC_BITS);
               end
               STEP_DTH: begin
                  nw_in    = nw_new;
                  z_in     = HEAD_W'(mid_sum >>> 1);
                  state_in = ST_WRAP;
               end
               STEP_COS: begin
                  step_in = STEP_PX;
                  mul_go  = 1'b1;
                  mul_a   = PROD_W'(flip_ff ? -cx_ff : cx_ff);
                  mul_b   = mt_mag;
                  mul_n   = mt[SUM_W-1];
               end
               STEP_PX: begin
                  pos_x_in = ddo_pkg::sat32(PROD_W'(pos_x_ff) + pstep);
                  step_in  = STEP_PY;
                  mul_go   = 1'b1;
                  mul_a    = PROD_W'(flip_ff ? -cy_ff : cy_ff);
                  mul_b    = mt_mag;
                  mul_n    = mt[SUM_W-1];
               end
               STEP_PY: begin
                  pos_y_in = ddo_pkg::sat32(PROD_W'(pos_y_ff) + pstep);
                  angle_in = ddo_pkg::sat32(PROD_W'(hw));
                  state_in = ST_DONE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_WRAP: begin
            if (z_ff > ddo_pkg::PI_Q29) begin
               z_in = z_ff - ddo_pkg::TWO_PI_Q29;
            end else if (z_ff < -ddo_pkg::PI_Q29) begin
               z_in = z_ff + ddo_pkg::TWO_PI_Q29;
            end
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            flip_in = 1'b0;
            if (z_ff > ddo_pkg::HALF_PI_Q29) begin
               z_in    = z_ff - ddo_pkg::PI_Q29;
               flip_in = 1'b1;
            end else if (z_ff < -ddo_pkg::HALF_PI_Q29) begin
               z_in    = z_ff + ddo_pkg::PI_Q29;
               flip_in = 1'b1;
            end
            cx_in    = ddo_pkg::GAIN_Q30;
            cy_in    = '0;
            cnt_in   = '0;
            state_in = ST_CORD;
         end
         ST_CORD: begin
            if (!z_ff[HEAD_W-1]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               z_in  = z_ff - at;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               z_in  = z_ff + at;
            end
            if (cnt_ff == CORD_LAST) begin
               step_in  = STEP_COS;
               state_in = ST_NEXT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_x_in     = pos_x_ff;
               out_y_in     = pos_y_ff;
               out_head_in  = angle_ff;
               out_vr_in    = vr_ff;
               out_vl_in    = vl_ff;
               out_lin_in   = lin_ff;
               out_ang_in   = ang_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (mul_go) begin
         acc_in    = '0;
         mcand_in  = mul_a;
         mplier_in = mul_b;
         neg_in    = mul_n;
         cnt_in    = '0;
         state_in  = ST_MUL;
      end
      if (div_go) begin
         num_in   = div_n;
         cnt_in   = '0;
         state_in = ST_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= STEP_TR;
         cnt_ff        <= '0;
         dpc_ff        <= ddo_pkg::DPC_RESET;
         rate_ff       <= ddo_pkg::RATE_RESET;
         spacing_ff    <= ddo_pkg::SPACING_RESET;
         prev_right_ff <= '0;
         prev_left_ff  <= '0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         angle_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         cnt_ff        <= cnt_in;
         dpc_ff        <= dpc_in;
         rate_ff       <= rate_in;
         spacing_ff    <= spacing_in;
         prev_right_ff <= prev_right_in;
         prev_left_ff  <= prev_left_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         angle_ff      <= angle_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dl_ff       <= dl_in;
      tr_ff       <= tr_in;
      tl_ff       <= tl_in;
      vr_ff       <= vr_in;
      vl_ff       <= vl_in;
      lin_ff      <= lin_in;
      ang_ff      <= ang_in;
      nw_ff       <= nw_in;
      z_ff        <= z_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      flip_ff     <= flip_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      neg_ff      <= neg_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      ovf_ff      <= ovf_in;
      dneg_ff     <= dneg_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_head_ff <= out_head_in;
      out_vr_ff   <= out_vr_in;
      out_vl_ff   <= out_vl_in;
      out_lin_ff  <= out_lin_in;
      out_ang_ff  <= out_ang_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_x_position    = out_x_ff;
   assign rsp_y_position    = out_y_ff;
   assign rsp_heading       = out_head_ff;
   assign rsp_right_speed   = out_vr_ff;
   assign rsp_left_speed    = out_vl_ff;
   assign rsp_linear_speed  = out_lin_ff;
   assign rsp_angular_speed = out_ang_ff;

   // an accepted item always starts with the right wheel travel multiply
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_MUL && step_ff == STEP_TR))
      else $error("accepted item did not start the travel multiply");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORD) |-> (cnt_ff <= CORD_LAST))
      else $error("cordic iteration count out of range");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !(rsp_valid_ff && rsp_stall))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished item not moved to the output register");

   // restoring divider keeps its remainder below the divisor unless the quotient overflows
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff != '0 && !ovf_ff) |-> (rem_ff < sp))
      else $error("divider remainder not below spacing");

endmodule

// ----- tb/sv/differential_drive_odometry_tb.sv -----
// self-checking testbench for the differential drive odometry block
module differential_drive_odometry_tb;

   localparam int DATA_W       = ddo_pkg::DATA_W;
   localparam int DPC_W        = ddo_pkg::DPC_W;
   localparam int RATE_W       = ddo_pkg::RATE_W;
   localparam int SPACING_W    = ddo_pkg::SPACING_W;
   localparam int CSR_INDEX_W  = ddo_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W   = ddo_pkg::CSR_DATA_W;
   localparam int FRAC_BITS    = ddo_pkg::FRAC_BITS;
   localparam int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS;

   typedef struct packed {
      logic signed [DATA_W-1:0] x_position;
      logic signed [DATA_W-1:0] y_position;
      logic signed [DATA_W-1:0] heading;
      logic signed [DATA_W-1:0] right_speed;
      logic signed [DATA_W-1:0] left_speed;
      logic signed [DATA_W-1:0] linear_speed;
      logic signed [DATA_W-1:0] angular_speed;
   } pose_speed_type;

   class odometry_scoreboard;
      pose_speed_type pending_q[$];
      int          mismatches;
      int          results_seen;
      int          samples_taken;
      longint      atan_q29_tab[30];
      logic [DPC_W-1:0]     dpc;
      logic [RATE_W-1:0]    rate;
      logic [SPACING_W-1:0] spacing;
      logic [31:0] prev_r, prev_l, pos_x, pos_y, angle;

      function new();
         longint unsigned acc, term;
         atan_q29_tab[0] = 421657428;
         for (int i = 1; i < 30; i++) begin
            acc = 0;
            for (int k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
               term = (64'd1 << (60 - i * (2 * k + 1))) / longint'(2 * k + 1);
               if (k % 2 == 1) acc = acc - term;
               else acc = acc + term;
            end
            atan_q29_tab[i] = longint'((acc + (64'd1 << 30)) >> 31);
         end
         clear();
      endfunction

      function void clear();
         dpc = ddo_pkg::DPC_RESET;
         rate = ddo_pkg::RATE_RESET;
         spacing = ddo_pkg::SPACING_RESET;
         prev_r = 0;
         prev_l = 0;
         pos_x = 0;
         pos_y = 0;
         angle = 0;
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint unsigned div_scaled(longint unsigned num, int s,
                                           longint unsigned den, longint unsigned cap);
         longint unsigned q, r;
         q = num / den;
         r = num % den;
         if (q > cap) return cap;
         for (int i = 0; i < s; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
               r = r - den;
               q = q | 1;
            end
            if (q > cap) return cap;
         end
         return q;
      endfunction

      function void accept_sample(logic [31:0] r, logic [31:0] l);
         longint dr, dl, tr, tl, sum, lin, n, ang, dth, old, nw, mid, mt, cx, sy, nx, z;
         longint unsigned us, un, m, q, sp;
         logic [31:0] d;
         bit flip;
         pose_speed_type e;
         sp = (spacing == 0) ? 1 : longint'(spacing);
         d = r - prev_r;
         dr = longint'(signed'(d));
         d = l - prev_l;
         dl = -longint'(signed'(d));
         prev_r = r;
         prev_l = l;
         tr = (dr * longint'(dpc)) >>> (32 - FRAC_BITS);
         tl = (dl * longint'(dpc)) >>> (32 - FRAC_BITS);
         e.right_speed = 32'(clamp32(tr * longint'(rate)));
         e.left_speed = 32'(clamp32(tl * longint'(rate)));
         sum = tr + tl;
         us = (sum < 0) ? -sum : sum;
         m = us * longint'(rate);
         if (sum >= 0) begin
            m = m >> 1;
            lin = (m > 64'd2147483647) ? 64'sd2147483647 : longint'(m);
         end else begin
            m = (m + 1) >> 1;
            lin = (m > 64'd2147483648) ? -64'sd2147483648 : -longint'(m);
         end
         e.linear_speed = 32'(lin);
         n = tr - tl;
         un = (n < 0) ? -n : n;
         q = div_scaled(un * longint'(rate), 16, sp, 64'd2147483648);
         ang = clamp32((n < 0) ? -longint'(q) : longint'(q));
         e.angular_speed = 32'(ang);
         q = div_scaled(un, 45 - FRAC_BITS, sp, 64'd2147483648);
         dth = (n < 0) ? -longint'(q) : longint'(q);
         old = longint'(signed'(angle));
         nw = old + dth;
         mid = (old + nw) >>> 1;
         if (mid > longint'(ddo_pkg::PI_Q29)) mid = mid - 2 * longint'(ddo_pkg::PI_Q29);
         else if (mid < -longint'(ddo_pkg::PI_Q29)) mid = mid + 2 * longint'(ddo_pkg::PI_Q29);
         flip = 0;
         if (mid > longint'(ddo_pkg::HALF_PI_Q29)) begin
            mid = mid - longint'(ddo_pkg::PI_Q29);
            flip = 1;
         end else if (mid < -longint'(ddo_pkg::HALF_PI_Q29)) begin
            mid = mid + longint'(ddo_pkg::PI_Q29);
            flip = 1;
         end
         cx = longint'(ddo_pkg::GAIN_Q30);
         sy = 0;
         z = mid;
         for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
            if (z >= 0) begin
               nx = cx - (sy >>> i);
               sy = sy + (cx >>> i);
               z = z - atan_q29_tab[i];
            end else begin
               nx = cx + (sy >>> i);
               sy = sy - (cx >>> i);
               z = z + atan_q29_tab[i];
            end
            cx = nx;
         end
         if (flip) begin
            cx = -cx;
            sy = -sy;
         end
         mt = sum >>> 1;
         if (mt > 64'sd4294967296) mt = 64'sd4294967296;
         if (mt < -64'sd4294967296) mt = -64'sd4294967296;
         pos_x = 32'(clamp32(longint'(signed'(pos_x)) + ((mt * cx) >>> 30)));
         pos_y = 32'(clamp32(longint'(signed'(pos_y)) + ((mt * sy) >>> 30)));
         if (nw > longint'(ddo_pkg::PI_Q29)) nw = nw - 2 * longint'(ddo_pkg::PI_Q29);
         if (nw < -longint'(ddo_pkg::PI_Q29)) nw = nw + 2 * longint'(ddo_pkg::PI_Q29);
         angle = 32'(clamp32(nw));
         e.x_position = pos_x;
         e.y_position = pos_y;
         e.heading = angle;
         pending_q.push_back(e);
         samples_taken++;
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch on result %0d, %s: expected %0d, got %0d",
                        results_seen, name, signed'(exp_v), signed'(act_v));
         end
      endfunction

      function void check_result(pose_speed_type a);
         pose_speed_type e;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result item with nothing expected");
            return;
         end
         e = pending_q.pop_front();
         compare_field("x_position", e.x_position, a.x_position);
         compare_field("y_position", e.y_position, a.y_position);
         compare_field("heading", e.heading, a.heading);
         compare_field("right_speed", e.right_speed, a.right_speed);
         compare_field("left_speed", e.left_speed, a.left_speed);
         compare_field("linear_speed", e.linear_speed, a.linear_speed);
         compare_field("angular_speed", e.angular_speed, a.angular_speed);
         results_seen++;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [DATA_W-1:0] req_right_count = 0;
   logic signed [DATA_W-1:0] req_left_count = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [DATA_W-1:0] rsp_x_position, rsp_y_position, rsp_heading;
   logic signed [DATA_W-1:0] rsp_right_speed, rsp_left_speed;
   logic signed [DATA_W-1:0] rsp_linear_speed, rsp_angular_speed;
   logic csr_write = 0;
   logic [CSR_INDEX_W-1:0] csr_index = ddo_pkg::CSR_DISTANCE_PER_COUNT;
   logic [CSR_DATA_W-1:0] csr_wdata = 0;

   odometry_scoreboard pose_board = new();
   int hold_requests = 0;
   int holds_served = 0;
   int long_hold_cycles = 0;
   logic [31:0] last_right = 0, last_left = 0;

   differential_drive_odometry i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_right_count(req_right_count), .req_left_count(req_left_count),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_x_position(rsp_x_position), .rsp_y_position(rsp_y_position),
      .rsp_heading(rsp_heading), .rsp_right_speed(rsp_right_speed),
      .rsp_left_speed(rsp_left_speed), .rsp_linear_speed(rsp_linear_speed),
      .rsp_angular_speed(rsp_angular_speed),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // receiver stall pattern, with an occasional long hold-off
   int stall_pct = 0;
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 300 == 0) stall_pct <= $urandom_range(0, 3) * 25;
      if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         long_hold_cycles <= 3000;
         rsp_stall <= 1;
      end else if (long_hold_cycles > 0) begin
         long_hold_cycles <= long_hold_cycles - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         pose_board.check_result({rsp_x_position, rsp_y_position, rsp_heading,
                                  rsp_right_speed, rsp_left_speed,
                                  rsp_linear_speed, rsp_angular_speed});
   end

   task automatic send_sample(logic [31:0] r, logic [31:0] l);
      req_valid <= 1;
      req_right_count <= r;
      req_left_count <= l;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
      end
      @(posedge clock);
      pose_board.accept_sample(r, l);
      last_right = r;
      last_left = l;
   endtask

   task automatic idle_cycles(int n);
      req_valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pose_board.pending_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         ddo_pkg::CSR_DISTANCE_PER_COUNT: pose_board.dpc = v[DPC_W-1:0];
         ddo_pkg::CSR_SAMPLE_RATE_HZ:     pose_board.rate = v[RATE_W-1:0];
         ddo_pkg::CSR_WHEEL_SPACING:      pose_board.spacing = v[SPACING_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(logic [CSR_DATA_W-1:0] d, logic [CSR_DATA_W-1:0] r,
                             logic [CSR_DATA_W-1:0] s);
      write_csr(ddo_pkg::CSR_DISTANCE_PER_COUNT, d);
      write_csr(ddo_pkg::CSR_SAMPLE_RATE_HZ, r);
      write_csr(ddo_pkg::CSR_WHEEL_SPACING, s);
   endtask

   // mostly smooth motion, some jumps and fully random counts
   function automatic logic [31:0] next_count(logic [31:0] prev);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return prev + 32'($signed($urandom_range(0, 8000)) - 4000);
      if (pick < 85) return prev + 32'($signed($urandom_range(0, 2000000)) - 1000000);
      return $urandom;
   endfunction

   task automatic random_phase(int items, bit with_hold);
      int burst;
      burst = 0;
      for (int i = 0; i < items; i++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 20);
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 600));
         end
         if (with_hold && i == items / 2) hold_requests = hold_requests + 1;
         send_sample(next_count(last_right), next_count(last_left));
         burst--;
      end
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      pose_board.clear();
      @(posedge clock);

      // directed: zero motion, counter wrap, extremes, turns
      send_sample(0, 0);
      send_sample(32'h7fff_ffff, 32'h8000_0000);
      send_sample(32'h8000_0000, 32'h7fff_ffff);
      send_sample(32'hffff_ffff, 32'h0000_0000);
      send_sample(32'h0000_0100, 32'hffff_ff00);
      send_sample(32'h0000_0500, 32'hffff_fb00);
      send_sample(32'h0000_0600, 32'h0000_0000);
      drain();
      set_config(31'h00ff_ffff, 31'd1, 31'd1);
      send_sample(32'h0000_1000, 32'h0000_0000);
      send_sample(32'h8000_0000, 32'h8000_0000);
      send_sample(32'h7fff_ffff, 32'h0000_0000);
      send_sample(32'h7fff_ff00, 32'h0000_0100);
      drain();
      set_config(31'd0, 31'h0000_ffff, 31'h7fff_ffff);
      send_sample(32'h1234_5678, 32'h8765_4321);
      send_sample(32'h0000_0000, 32'h0000_0000);
      drain();
      set_config(31'h0040_0000, 31'd0, 31'd0);
      send_sample(32'h0001_0000, 32'hffff_0000);
      send_sample(32'h0002_0000, 32'hfffd_0000);
      send_sample(32'hf000_0000, 32'h0000_0000);
      drain();
      set_config(31'h00ff_ffff, 31'h0000_ffff, 31'h0001_0000);
      send_sample(32'h0100_0000, 32'hff00_0000);
      send_sample(32'h0000_0000, 32'h0000_0000);
      drain();

      set_config(CSR_DATA_W'(ddo_pkg::DPC_RESET), CSR_DATA_W'(ddo_pkg::RATE_RESET),
                 ddo_pkg::SPACING_RESET);
      random_phase(500, 1);
      set_config(CSR_DATA_W'($urandom_range(0, 24'hff_ffff)),
                 CSR_DATA_W'($urandom_range(1, 2000)),
                 CSR_DATA_W'($urandom_range(1, 31'h7fff_ffff)));
      random_phase(300, 0);
      set_config(31'h00ff_ffff, 31'h0000_ffff, 31'h0000_8000);
      random_phase(200, 0);
      set_config(CSR_DATA_W'($urandom_range(0, 24'h0f_ffff)),
                 CSR_DATA_W'($urandom_range(0, 1000)),
                 CSR_DATA_W'($urandom_range(0, 31'h0100_0000)));
      random_phase(300, 1);
      set_config(CSR_DATA_W'(ddo_pkg::DPC_RESET), CSR_DATA_W'(ddo_pkg::RATE_RESET),
                 ddo_pkg::SPACING_RESET);
      random_phase(380, 0);

      $display("%0d samples sent over several configurations, %0d results checked",
               pose_board.samples_taken, pose_board.results_seen);
      if (pose_board.mismatches == 0 && pose_board.pending_q.size() == 0)
         $display("differential_drive_odometry test passed");
      else
         $display("differential_drive_odometry test failed");
      $finish;
   end

   initial begin
      #(20 * 8000000);
      $display("differential_drive_odometry test failed");
      $finish;
   end
endmodule

// ----- files.f -----
rtl/ddo_pkg.sv
rtl/differential_drive_odometry.sv
tb/sv/differential_drive_odometry_tb.sv
